### hw/rtl/adip_pkg.sv
// Package for the ASCII decimal integer parser.
// Holds the mode and status codes, the digit limit and the result record type.
// Used by adip_core and ascii_decimal_integer_parser; depends on nothing.
`timescale 1ns / 1ps

package adip_pkg;

   // Largest number of digits that one number may gather.
   localparam int MAX_DIGITS = 64;
   // Width of the digit counter, wide enough to hold MAX_DIGITS itself.
   localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

   // Number formats selected by the mode register.
   localparam logic [2:0] MODE_U32 = 3'd0;
   localparam logic [2:0] MODE_S32 = 3'd1;
   localparam logic [2:0] MODE_S16 = 3'd2;
   localparam logic [2:0] MODE_U16 = 3'd3;
   localparam logic [2:0] MODE_U8  = 3'd4;

   // Character codes of interest.
   localparam logic [7:0] CHAR_EOF   = 8'd25;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_EOF   = 2'd3
   } status_type;

   // Packed so that value sits in the lowest bits, then status, then stop_char.
   typedef struct packed {
      logic [7:0]  stop_char;
      status_type  status;
      logic [31:0] value;
   } result_type;

endpackage

### hw/rtl/adip_core.sv
// Parsing core of the ASCII decimal integer parser: number state and one-character step.
// Works out the next state and, when a number ends, the result record.
// Depends on adip_pkg.
`timescale 1ns / 1ps

module adip_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,    // consume char this cycle
   input  logic [7:0]           char,
   input  logic [2:0]           mode,
   output logic                 emit,       // char ends the current number
   output adip_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_MINUS  = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [31:0]                      mag_ff, mag_in;
   logic                             minus_ff, minus_in;
   logic                             ovf_ff, ovf_in;
   logic [adip_pkg::DIGIT_CNT_W-1:0] cnt_ff, cnt_in;

   logic        is_blank, is_digit, signed_mode, take, range_bad;
   logic [3:0]  digit;
   logic [31:0] mag_next;
   logic        ovf_next;

   always_comb begin
      is_blank    = (char == adip_pkg::CHAR_SPACE) ||
                    ((char >= adip_pkg::CHAR_TAB) && (char <= adip_pkg::CHAR_CR));
      is_digit    = (char >= adip_pkg::CHAR_ZERO) && (char <= adip_pkg::CHAR_NINE);
      signed_mode = (mode == adip_pkg::MODE_S32) || (mode == adip_pkg::MODE_S16);
      digit       = char[3:0];
      // Times ten as two shifted copies; the sum wraps modulo 2^32.
      mag_next    = {mag_ff[28:0], 3'b000} + {mag_ff[30:0], 1'b0} + {28'd0, digit};
      ovf_next    = ovf_ff || (mag_ff > 32'd429496729) ||
                    ((mag_ff == 32'd429496729) && (digit > 4'd5));
   end

   // Decide whether the character is taken as a digit, skipped, or ends the number.
   always_comb begin
      phase_in = phase_ff;
      minus_in = minus_ff;
      take     = 1'b0;
      emit     = 1'b0;
      unique case (phase_ff)
         PH_DIGITS: begin
            if (is_digit && (cnt_ff < adip_pkg::DIGIT_CNT_W'(adip_pkg::MAX_DIGITS))) begin
               take = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_MINUS: begin
            if (is_digit) begin
               take     = 1'b1;
               phase_in = PH_DIGITS;
            end else if (!is_blank) begin
               emit = 1'b1;
            end
         end
         default: begin
            // The unused phase code behaves as the skipping phase.
            phase_in = PH_SKIP;
            if (is_blank) begin
               phase_in = PH_SKIP;
            end else if ((char == adip_pkg::CHAR_MINUS) && signed_mode) begin
               minus_in = 1'b1;
               phase_in = PH_MINUS;
            end else if (is_digit) begin
               take     = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               emit = 1'b1;
            end
         end
      endcase

      mag_in = take ? mag_next : mag_ff;
      ovf_in = take ? ovf_next : ovf_ff;
      cnt_in = take ? cnt_ff + 1'b1 : cnt_ff;

      // A finished number always returns the state to its cleared values.
      if (emit) begin
         phase_in = PH_SKIP;
         minus_in = 1'b0;
         mag_in   = '0;
         ovf_in   = 1'b0;
         cnt_in   = '0;
      end
   end

   // Result for a number ended by the current character.
   always_comb begin
      range_bad = ovf_ff;
      unique case (mode)
         adip_pkg::MODE_S32:
            if (minus_ff ? (mag_ff > 32'h8000_0000) : (mag_ff > 32'h7FFF_FFFF))
               range_bad = 1'b1;
         adip_pkg::MODE_S16:
            if (minus_ff ? (mag_ff > 32'd32768) : (mag_ff > 32'd32767))
               range_bad = 1'b1;
         adip_pkg::MODE_U16:
            if (mag_ff > 32'd65535)
               range_bad = 1'b1;
         adip_pkg::MODE_U8:
            if (mag_ff > 32'd255)
               range_bad = 1'b1;
         default: ;
      endcase

      result.stop_char = char;
      result.value     = '0;
      if (phase_ff != PH_DIGITS) begin
         result.status = adip_pkg::STATUS_NONE;
      end else if (range_bad) begin
         result.status = adip_pkg::STATUS_RANGE;
      end else if (char == adip_pkg::CHAR_EOF) begin
         result.status = adip_pkg::STATUS_EOF;
      end else begin
         result.status = adip_pkg::STATUS_OK;
         result.value  = (signed_mode && minus_ff) ? (32'd0 - mag_ff) : mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         mag_ff   <= '0;
         minus_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         minus_ff <= minus_in;
         ovf_ff   <= ovf_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### hw/rtl/ascii_decimal_integer_parser.sv
// Top level of the ASCII decimal integer parser.
// Holds the request register, the result register and the mode register.
// Depends on adip_pkg and adip_core.
`timescale 1ns / 1ps

// Usage
// Each request on the req_ channel carries one ASCII character of a text stream.
// Leading whitespace is skipped; in the signed modes a single '-' is accepted and may be
// followed by more whitespace; up to 64 digits are then gathered. The first character
// that does not continue the number ends it, and one result appears on the rsp_
// channel holding the value, a status and that stop character. All other requests
// give no result.
// The csr_ channel writes the three-bit number mode (0 u32, 1 s32, 2 s16, 3 u16,
// 4 u8; codes 5 to 7 act as u32). It is always ready and should only be written
// while the block is idle.
// A request accepted into the request register is processed there by the parsing core,
// and its result is registered in the result register, which drives rsp_tvalid.
// Throughput: one request per cycle unless an ending character waits on a stalled result,
// set by the combinational state update (multiply by ten, add and compare) in the core.
// A stalled receiver holds the result register; the request register keeps taking
// characters, and only a character that would end another number waits there,
// which holds req_tready low until the result is taken.
// Reset (synchronous, active high) clears both valid flags, the number state
// and the mode, which returns to u32.

module ascii_decimal_integer_parser (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] value, [33:32] status, [41:34] stop_char
   // Mode register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);

   logic                 req_valid_ff, req_valid_in;
   logic [7:0]           req_char_ff, req_char_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   adip_pkg::result_type rsp_data_ff, rsp_data_in;
   logic [2:0]           mode_ff, mode_in;

   logic                 emit;
   logic                 advance;
   adip_pkg::result_type result;

   adip_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .char    (req_char_ff),
      .mode    (mode_ff),
      .emit    (emit),
      .result  (result)
   );

   // The held character moves on unless it ends a number while the result
   // register is still full and not being taken.
   always_comb begin
      advance    = req_valid_ff && (!emit || !rsp_valid_ff || rsp_tready);
      req_tready = !req_valid_ff || advance;
      csr_ready  = 1'b1;

      req_valid_in = req_tvalid ? 1'b1 : (req_valid_ff && !advance);
      req_char_in  = (req_tvalid && req_tready) ? req_tdata : req_char_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end

      mode_in = csr_valid ? csr_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= adip_pkg::MODE_U32;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
      req_char_ff <= req_char_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule
